// File: rtl/core/ultrasonic_echo_hit_counter_core_defines.svh
// Assertion macros for the ultrasonic echo hit counter core.
`ifndef ULTRASONIC_ECHO_HIT_COUNTER_CORE_DEFINES_SVH
`define ULTRASONIC_ECHO_HIT_COUNTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define UEH_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ueh assertion failed");
`define UEH_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `UEH_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define UEH_ASSERT(lbl, clk, rst_n, prop)
`define UEH_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/core/ueh_pkg.sv
package ueh_pkg;

  localparam int unsigned CFG_TIME_W   = 24;
  localparam int unsigned CFG_THRESH_W = 16;
  localparam int unsigned CFG_TRIG_W   = 8;
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned APB_ADDR_W   = 5;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned REG_IDX_W    = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE         = 3'd0,
    CMD_START        = 3'd1,
    CMD_STOP         = 3'd2,
    CMD_END_SCREEN   = 3'd3,
    CMD_START_SCREEN = 3'd4,
    CMD_OTHER        = 3'd5
  } cmd_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_HIT_THRESHOLD = 3'd0,
    REG_TIMEOUT       = 3'd1,
    REG_HIT_HOLDOFF   = 3'd2,
    REG_MISS_REARM    = 3'd3,
    REG_IDLE_POLL     = 3'd4,
    REG_TRIGGER_WIDTH = 3'd5
  } reg_idx_e;

  localparam logic [CFG_THRESH_W-1:0] RST_HIT_THRESHOLD = 16'd1200;
  localparam logic [CFG_TIME_W-1:0]   RST_TIMEOUT       = 24'd10000000;
  localparam logic [CFG_TIME_W-1:0]   RST_HIT_HOLDOFF   = 24'd500000;
  localparam logic [CFG_TIME_W-1:0]   RST_MISS_REARM    = 24'd50000;
  localparam logic [CFG_TIME_W-1:0]   RST_IDLE_POLL     = 24'd500000;
  localparam logic [CFG_TRIG_W-1:0]   RST_TRIGGER_WIDTH = 8'd10;

  typedef struct packed {
    logic [CFG_THRESH_W-1:0] hit_threshold;
    logic [CFG_TIME_W-1:0]   timeout;
    logic [CFG_TIME_W-1:0]   hit_holdoff;
    logic [CFG_TIME_W-1:0]   miss_rearm;
    logic [CFG_TIME_W-1:0]   idle_poll;
    logic [CFG_TRIG_W-1:0]   trigger_width;
  } cfg_t;

endpackage

// File: rtl/core/ueh_cfg_regs.sv
module ueh_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ueh_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ueh_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ueh_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output ueh_pkg::cfg_t                   cfg_o
);
  import ueh_pkg::*;

  cfg_t                 cfg_q, cfg_d;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_HIT_THRESHOLD: cfg_d.hit_threshold = pwdata[CFG_THRESH_W-1:0];
        REG_TIMEOUT:       cfg_d.timeout       = pwdata[CFG_TIME_W-1:0];
        REG_HIT_HOLDOFF:   cfg_d.hit_holdoff   = pwdata[CFG_TIME_W-1:0];
        REG_MISS_REARM:    cfg_d.miss_rearm    = pwdata[CFG_TIME_W-1:0];
        REG_IDLE_POLL:     cfg_d.idle_poll     = pwdata[CFG_TIME_W-1:0];
        REG_TRIGGER_WIDTH: cfg_d.trigger_width = pwdata[CFG_TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HIT_THRESHOLD: prdata = APB_DATA_W'(cfg_q.hit_threshold);
      REG_TIMEOUT:       prdata = APB_DATA_W'(cfg_q.timeout);
      REG_HIT_HOLDOFF:   prdata = APB_DATA_W'(cfg_q.hit_holdoff);
      REG_MISS_REARM:    prdata = APB_DATA_W'(cfg_q.miss_rearm);
      REG_IDLE_POLL:     prdata = APB_DATA_W'(cfg_q.idle_poll);
      REG_TRIGGER_WIDTH: prdata = APB_DATA_W'(cfg_q.trigger_width);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hit_threshold <= RST_HIT_THRESHOLD;
      cfg_q.timeout       <= RST_TIMEOUT;
      cfg_q.hit_holdoff   <= RST_HIT_HOLDOFF;
      cfg_q.miss_rearm    <= RST_MISS_REARM;
      cfg_q.idle_poll     <= RST_IDLE_POLL;
      cfg_q.trigger_width <= RST_TRIGGER_WIDTH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: rtl/core/ueh_tick_engine.sv
`include "ultrasonic_echo_hit_counter_core_defines.svh"

module ueh_tick_engine #(
  parameter int unsigned TIME_BITS  = 24,
  parameter int unsigned SCORE_BITS = 17,
  parameter int unsigned RES_W      = TIME_BITS + SCORE_BITS + 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          echo_level_i,
  input  logic [ueh_pkg::CMD_W-1:0]     command_i,
  input  ueh_pkg::cfg_t                 cfg_i,
  output logic [RES_W-1:0]              res_o
);
  import ueh_pkg::*;

  localparam int unsigned EXT_W = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;
  localparam logic [TIME_BITS-1:0]  TIME_MAX     = {TIME_BITS{1'b1}};
  localparam logic [EXT_W-1:0]      TIME_MAX_EXT = EXT_W'(TIME_MAX);
  localparam logic [SCORE_BITS-1:0] SCORE_MAX    = {1'b0, {(SCORE_BITS-1){1'b1}}};
  localparam logic [SCORE_BITS-1:0] SCORE_NEG1   = {SCORE_BITS{1'b1}};
  localparam logic [SCORE_BITS-1:0] SCORE_NEG2   = {{(SCORE_BITS-1){1'b1}}, 1'b0};

  function automatic logic [TIME_BITS-1:0] clamp_time(input logic [CFG_TIME_W-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    if (ext > TIME_MAX_EXT) begin
      return TIME_MAX;
    end
    return ext[TIME_BITS-1:0];
  endfunction

  logic                  counting_q, counting_d;
  logic                  armed_q, armed_d;
  logic                  echo_seen_q, echo_seen_d;
  logic                  measuring_q, measuring_d;
  logic [TIME_BITS-1:0]  interval_q, interval_d;
  logic [CFG_TRIG_W-1:0] pulse_q, pulse_d;
  logic [TIME_BITS-1:0]  width_q, width_d;
  logic                  last_echo_q;
  logic [SCORE_BITS-1:0] score_q, score_d;

  logic rise, fall;
  logic timeout_ev, done, hit, reloaded;

  assign rise = echo_level_i & ~last_echo_q;
  assign fall = ~echo_level_i & last_echo_q;

  always_comb begin
    counting_d  = counting_q;
    score_d     = score_q;
    armed_d     = armed_q;
    echo_seen_d = echo_seen_q;
    measuring_d = measuring_q;
    interval_d  = interval_q;
    timeout_ev  = 1'b0;
    done        = 1'b0;
    hit         = 1'b0;
    reloaded    = 1'b0;

    case (command_i)
      CMD_NONE: ;
      CMD_START: begin
        score_d    = '0;
        counting_d = 1'b1;
      end
      CMD_STOP: begin
        score_d    = '0;
        counting_d = 1'b0;
      end
      CMD_END_SCREEN: begin
        score_d    = SCORE_NEG1;
        counting_d = 1'b0;
      end
      CMD_START_SCREEN: begin
        score_d    = SCORE_NEG2;
        counting_d = 1'b0;
      end
      default: begin
        score_d = '0;
      end
    endcase

    pulse_d = (pulse_q != '0) ? pulse_q - 1'b1 : pulse_q;
    width_d = (measuring_q && width_q != TIME_MAX) ? width_q + 1'b1 : width_q;

    if (rise) begin
      if (counting_d && armed_q) begin
        width_d     = '0;
        measuring_d = 1'b1;
        armed_d     = 1'b0;
      end
    end else if (fall) begin
      if (counting_d && !armed_q && measuring_q) begin
        measuring_d = 1'b0;
        done        = 1'b1;
        echo_seen_d = 1'b1;
        reloaded    = 1'b1;
        if (width_d < TIME_BITS'(cfg_i.hit_threshold)) begin
          hit = 1'b1;
          if (score_d != SCORE_MAX) begin
            score_d = score_d + 1'b1;
          end
          interval_d = clamp_time(cfg_i.hit_holdoff);
        end else begin
          interval_d = clamp_time(cfg_i.miss_rearm);
        end
      end
    end

    if (!reloaded) begin
      if (interval_q <= TIME_BITS'(1)) begin
        timeout_ev  = ~echo_seen_d & counting_d;
        echo_seen_d = 1'b0;
        if (counting_d) begin
          armed_d    = 1'b1;
          interval_d = clamp_time(cfg_i.timeout);
          pulse_d    = cfg_i.trigger_width;
        end else begin
          interval_d = clamp_time(cfg_i.idle_poll);
        end
      end else begin
        interval_d = interval_q - 1'b1;
      end
    end
  end

  assign res_o = {(pulse_d != '0), score_d, counting_d, timeout_ev, done, width_d, hit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counting_q  <= 1'b0;
      armed_q     <= 1'b1;
      echo_seen_q <= 1'b0;
      measuring_q <= 1'b0;
      interval_q  <= clamp_time(RST_IDLE_POLL);
      pulse_q     <= '0;
      width_q     <= '0;
      last_echo_q <= 1'b0;
      score_q     <= SCORE_NEG2;
    end else if (accept_i) begin
      counting_q  <= counting_d;
      armed_q     <= armed_d;
      echo_seen_q <= echo_seen_d;
      measuring_q <= measuring_d;
      interval_q  <= interval_d;
      pulse_q     <= pulse_d;
      width_q     <= width_d;
      last_echo_q <= echo_level_i;
      score_q     <= score_d;
    end
  end

  `UEH_ASSERT(a_done_ends_measure, clk_i, rst_ni, accept_i && done |=> !measuring_q)
  `UEH_ASSERT(a_timeout_counting, clk_i, rst_ni, accept_i && timeout_ev |=> counting_q)
  `UEH_ASSERT(a_hold_without_req, clk_i, rst_ni, !accept_i |=> $stable(interval_q) && $stable(score_q))
  `UEH_ASSERT_NEVER(a_hit_without_done, clk_i, rst_ni, hit && !done)

endmodule

// File: rtl/core/ueh_result_fifo.sv
module ueh_result_fifo #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;
  logic              push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_valid_o & rd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: rtl/core/ultrasonic_echo_hit_counter_core.sv
// Channel   Handshake                        Payload
// -------   ------------------------------   ------------------------------------------
// in        in_valid_i / in_ready_o          echo_level_i, command_i
// out       out_valid_o / out_ready_i        trigger_level_o, score_o, counting_on_o,
//                                            timeout_event_o, measure_done_o,
//                                            echo_width_o, hit_event_o
// cfg       psel, penable, pwrite / pready   paddr, pwdata, prdata
//
// One request per cycle while in_ready_o is high; the tick engine updates on accept.
// A request's result is registered into the result queue on acceptance.
// A two-entry result queue decouples the sides; in_ready_o drops only when it is full.
// Reset loads the register defaults and the idle poll interval; no clearing pass.
module ultrasonic_echo_hit_counter_core #(
  parameter int unsigned TIME_BITS  = 24,
  parameter int unsigned SCORE_BITS = 17
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            echo_level_i,
  input  logic [ueh_pkg::CMD_W-1:0]       command_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            trigger_level_o,
  output logic signed [SCORE_BITS-1:0]    score_o,
  output logic                            counting_on_o,
  output logic                            timeout_event_o,
  output logic                            measure_done_o,
  output logic [TIME_BITS-1:0]            echo_width_o,
  output logic                            hit_event_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ueh_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ueh_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ueh_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import ueh_pkg::*;

  localparam int unsigned RES_W = TIME_BITS + SCORE_BITS + 5;

  cfg_t             cfg;
  logic             accept;
  logic [RES_W-1:0] res_in;
  logic [RES_W-1:0] res_out;

  assign accept = in_valid_i & in_ready_o;

  ueh_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ueh_tick_engine #(
    .TIME_BITS  (TIME_BITS),
    .SCORE_BITS (SCORE_BITS),
    .RES_W      (RES_W)
  ) u_tick_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .echo_level_i (echo_level_i),
    .command_i    (command_i),
    .cfg_i        (cfg),
    .res_o        (res_in)
  );

  ueh_result_fifo #(
    .DATA_W (RES_W)
  ) u_result_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (in_valid_i),
    .wr_ready_o (in_ready_o),
    .wr_data_i  (res_in),
    .rd_valid_o (out_valid_o),
    .rd_ready_i (out_ready_i),
    .rd_data_o  (res_out)
  );

  assign hit_event_o     = res_out[0];
  assign echo_width_o    = res_out[TIME_BITS:1];
  assign measure_done_o  = res_out[TIME_BITS+1];
  assign timeout_event_o = res_out[TIME_BITS+2];
  assign counting_on_o   = res_out[TIME_BITS+3];
  assign score_o         = $signed(res_out[TIME_BITS+SCORE_BITS+3:TIME_BITS+4]);
  assign trigger_level_o = res_out[RES_W-1];

endmodule
